// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Assertions compile in simulation only; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Same-cycle implication checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// File: design/jesc_pkg.sv
// ----------------------------------------------------------------------------
// jesc_pkg - shared types and constants of the JSON escaper
// Command format between front and back, character codes, hex helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jesc_pkg;

  localparam int CFG_W        = 13;
  localparam int MAX_CAPACITY = 4096;
  localparam int QUEUE_DEPTH  = 4;
  localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CTRL   = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;

  // UTF-8 class masks and patterns
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  // what follows the flushed held bytes in one command
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_NUL,
    TAIL_ESC2,
    TAIL_ESC6
  } tail_kind_t;

  typedef struct packed {
    logic [2:0][7:0] held;       // held sequence, entry 0 first
    logic [1:0]      flush_n;    // held bytes to emit first
    tail_kind_t      kind;
    logic [7:0]      tail_byte;  // plain byte, escape letter or source byte
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = CH_ZERO + {4'd0, nib};
    else             r = CH_A + {4'd0, nib} - 8'd10;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/jesc_front.sv
// ----------------------------------------------------------------------------
// jesc_front - input side of the JSON escaper
// Classifies each source byte, tracks fill and held UTF-8 state, and posts
// one command per byte that produces output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jesc_front #(
  parameter int MAX_CAPACITY = jesc_pkg::MAX_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [jesc_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,    // in_byte
  input  wire jesc_pkg::q_status_t        q_stat,
  output logic                            push,
  output jesc_pkg::cmd_t                  cmd
);

  localparam int WC_W  = $clog2(MAX_CAPACITY);
  localparam int CAPW0 = $clog2(MAX_CAPACITY + 1);
  localparam int CAP_W = (CAPW0 > jesc_pkg::CFG_W) ? CAPW0 : jesc_pkg::CFG_W;
  localparam int CMP_W = CAP_W + 1;

  logic [jesc_pkg::CFG_W-1:0] out_capacity;
  logic [WC_W-1:0]            written_count, written_count_next;
  logic                       stopped, stopped_next;
  logic [2:0][7:0]            held, held_next;
  logic [1:0]                 held_count, held_count_next;
  logic [1:0]                 held_needed, held_needed_next;

  logic             accept;
  logic [7:0]       b;
  logic [CMP_W-1:0] cap_raw, cap_eff, wc_ext, wc_plus1, wc_plus_len;
  logic [2:0]       esc_len;
  logic [7:0]       esc_char;
  logic             is_cont;
  logic [1:0]       lead_need;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;

  // effective capacity: zero reads as one, saturate at the maximum
  always_comb begin
    cap_raw = CMP_W'(out_capacity);
    if (cap_raw == '0)                        cap_eff = CMP_W'(1);
    else if (cap_raw > CMP_W'(MAX_CAPACITY))  cap_eff = CMP_W'(MAX_CAPACITY);
    else                                      cap_eff = cap_raw;
  end

  // escape classification
  always_comb begin
    esc_len  = 3'd0;
    esc_char = b;
    priority if (b == jesc_pkg::CH_QUOTE || b == jesc_pkg::CH_BSLASH) begin
      esc_len = 3'd2;
    end else if (b == jesc_pkg::CH_LF) begin
      esc_len = 3'd2; esc_char = jesc_pkg::CH_N;
    end else if (b == jesc_pkg::CH_CR) begin
      esc_len = 3'd2; esc_char = jesc_pkg::CH_R;
    end else if (b == jesc_pkg::CH_TAB) begin
      esc_len = 3'd2; esc_char = jesc_pkg::CH_T;
    end else if (b < jesc_pkg::CH_CTRL) begin
      esc_len = 3'd6;
    end else begin
      esc_len = 3'd0;
    end
  end

  // UTF-8 class
  always_comb begin
    is_cont = (b & jesc_pkg::MASK_CONT) == jesc_pkg::PAT_CONT;
    priority if ((b & jesc_pkg::MASK_LEAD2) == jesc_pkg::PAT_LEAD2) lead_need = 2'd1;
    else if ((b & jesc_pkg::MASK_LEAD3) == jesc_pkg::PAT_LEAD3)     lead_need = 2'd2;
    else if ((b & jesc_pkg::MASK_LEAD4) == jesc_pkg::PAT_LEAD4)     lead_need = 2'd3;
    else                                                           lead_need = 2'd0;
  end

  assign wc_ext      = CMP_W'(written_count);
  assign wc_plus1    = wc_ext + CMP_W'(1);
  assign wc_plus_len = wc_ext + CMP_W'(esc_len);

  // per-byte decision and command build
  always_comb begin
    written_count_next = written_count;
    stopped_next       = stopped;
    held_next          = held;
    held_count_next    = held_count;
    held_needed_next   = held_needed;
    push               = 1'b0;
    cmd.held           = held;
    cmd.flush_n        = held_count;
    cmd.kind           = jesc_pkg::TAIL_NONE;
    cmd.tail_byte      = b;
    if (accept) begin
      priority if (b == jesc_pkg::CH_NUL) begin
        // terminator: flush only if room is left, then NUL, clear state
        push          = 1'b1;
        cmd.kind      = jesc_pkg::TAIL_NUL;
        cmd.flush_n   = (!stopped && wc_plus1 < cap_eff) ? held_count : 2'd0;
        written_count_next = '0;
        stopped_next       = 1'b0;
        held_count_next    = 2'd0;
        held_needed_next   = 2'd0;
      end else if (stopped) begin
        // ignore until terminator
      end else if (wc_plus1 >= cap_eff ||
                   (esc_len != 3'd0 && wc_plus_len >= cap_eff)) begin
        // buffer full or escape does not fit
        stopped_next     = 1'b1;
        held_count_next  = 2'd0;
        held_needed_next = 2'd0;
      end else if (esc_len != 3'd0) begin
        push          = 1'b1;
        cmd.kind      = (esc_len == 3'd2) ? jesc_pkg::TAIL_ESC2 : jesc_pkg::TAIL_ESC6;
        cmd.tail_byte = (esc_len == 3'd2) ? esc_char : b;
        written_count_next = WC_W'(wc_plus_len);
        held_count_next    = 2'd0;
        held_needed_next   = 2'd0;
      end else if (is_cont && held_count != 2'd0) begin
        written_count_next = WC_W'(wc_plus1);
        if (held_count >= held_needed) begin
          push             = 1'b1;
          cmd.kind         = jesc_pkg::TAIL_BYTE;
          held_count_next  = 2'd0;
          held_needed_next = 2'd0;
        end else begin
          // append continuation byte
          for (int i = 0; i < 3; i++) begin
            if (held_count == 2'(i)) held_next[i] = b;
          end
          held_count_next = held_count + 2'd1;
        end
      end else begin
        written_count_next = WC_W'(wc_plus1);
        held_needed_next   = lead_need;
        if (lead_need != 2'd0) begin
          // new lead byte: flush old sequence, hold this one
          push            = (held_count != 2'd0);
          cmd.kind        = jesc_pkg::TAIL_NONE;
          held_next[0]    = b;
          held_count_next = 2'd1;
        end else begin
          push            = 1'b1;
          cmd.kind        = jesc_pkg::TAIL_BYTE;
          held_count_next = 2'd0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity  <= jesc_pkg::CAP_RESET;
      written_count <= '0;
      stopped       <= 1'b0;
      held_count    <= 2'd0;
      held_needed   <= 2'd0;
    end else begin
      if (cfg_wen) out_capacity <= cfg_wdata;
      written_count <= written_count_next;
      stopped       <= stopped_next;
      held_count    <= held_count_next;
      held_needed   <= held_needed_next;
    end
  end

  // held bytes carry no reset
  always_ff @(posedge clk) begin
    held <= held_next;
  end

endmodule

`default_nettype wire

// File: design/jesc_queue.sv
// ----------------------------------------------------------------------------
// jesc_queue - command queue between front and back
// Small register FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jesc_queue #(
  parameter int DEPTH = jesc_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire jesc_pkg::cmd_t       cmd_in,
  input  wire logic                 pop,
  output jesc_pkg::cmd_t            head,
  output jesc_pkg::q_status_t       q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jesc_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= cmd_in;
  end

endmodule

`default_nettype wire

// File: design/jesc_back.sv
// ----------------------------------------------------------------------------
// jesc_back - output side of the JSON escaper
// Expands the head command into output bytes, one per cycle while m_tready
// allows, into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jesc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire jesc_pkg::cmd_t       head,
  input  wire jesc_pkg::q_status_t  q_stat,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,    // out_byte
  output logic                      m_tlast
);

  logic [3:0] pos;
  logic [3:0] total;
  logic [3:0] tail_len;
  logic [2:0] tpos;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic       load;
  logic       final_pos;

  // bytes contributed by the tail
  always_comb begin
    unique case (head.kind)
      jesc_pkg::TAIL_NONE: tail_len = 4'd0;
      jesc_pkg::TAIL_BYTE: tail_len = 4'd1;
      jesc_pkg::TAIL_NUL:  tail_len = 4'd1;
      jesc_pkg::TAIL_ESC2: tail_len = 4'd2;
      jesc_pkg::TAIL_ESC6: tail_len = 4'd6;
      default:             tail_len = 4'd0;
    endcase
  end

  assign total     = {2'd0, head.flush_n} + tail_len;
  assign final_pos = (pos == total - 4'd1);
  assign tpos      = 3'(pos - {2'd0, head.flush_n});

  // byte at the current position
  always_comb begin
    last_sel = 1'b0;
    byte_sel = head.tail_byte;
    if (pos < {2'd0, head.flush_n}) begin
      unique case (pos[1:0])
        2'd0:    byte_sel = head.held[0];
        2'd1:    byte_sel = head.held[1];
        default: byte_sel = head.held[2];
      endcase
    end else begin
      unique case (head.kind)
        jesc_pkg::TAIL_NUL: begin
          byte_sel = jesc_pkg::CH_NUL;
          last_sel = 1'b1;
        end
        jesc_pkg::TAIL_ESC2: begin
          byte_sel = (tpos == 3'd0) ? jesc_pkg::CH_BSLASH : head.tail_byte;
        end
        jesc_pkg::TAIL_ESC6: begin
          unique case (tpos)
            3'd0:    byte_sel = jesc_pkg::CH_BSLASH;
            3'd1:    byte_sel = jesc_pkg::CH_U;
            3'd2:    byte_sel = jesc_pkg::CH_ZERO;
            3'd3:    byte_sel = jesc_pkg::CH_ZERO;
            3'd4:    byte_sel = jesc_pkg::hex_digit(head.tail_byte[7:4]);
            default: byte_sel = jesc_pkg::hex_digit(head.tail_byte[3:0]);
          endcase
        end
        default: byte_sel = head.tail_byte;
      endcase
    end
  end

  assign load = !q_stat.empty && (!m_tvalid || m_tready);
  assign pop  = load && final_pos;

  // position counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pos      <= final_pos ? 4'd0 : pos + 4'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tlast <= last_sel;
    end
  end

endmodule

`default_nettype wire

// File: design/json_escape_utf8_truncate.sv
// ----------------------------------------------------------------------------
// json_escape_utf8_truncate - JSON string escaper with UTF-8 safe truncation
// Streams a NUL-terminated string in, streams the escaped string out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one source byte per transfer; a zero byte ends the string.
//   m_* carries one output byte per transfer; m_tlast marks the final NUL.
//   cfg_wen/cfg_wdata set the output capacity (NUL included) between strings.
// Path: a byte that produces output is written to the command queue, then
//   expanded from the queue head into the output register that drives m_*.
// Throughput: input takes one byte per cycle while the command queue has
//   room. Output runs at one byte per cycle, set by the output register,
//   while m_tready is high; a source byte yields 0 to 9 output bytes (held
//   UTF-8 bytes plus escape).
// Reset: synchronous; clears fill count, stop flag, held byte count, queue and
//   output valid, and sets the capacity to 4096.
// Stall: when m_tready is low the output byte holds, the back end waits, the
//   queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module json_escape_utf8_truncate #(
  parameter int MAX_CAPACITY = jesc_pkg::MAX_CAPACITY,
  parameter int QUEUE_DEPTH  = jesc_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [jesc_pkg::CFG_W-1:0] cfg_wdata,   // out_capacity
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,     // in_byte
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [7:0]                      m_tdata,     // out_byte
  output logic                            m_tlast      // out_last
);

  logic                push, pop;
  jesc_pkg::cmd_t      cmd, head;
  jesc_pkg::q_status_t q_stat;

  // classify and track state
  jesc_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (cmd)
  );

  // command queue
  jesc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .cmd_in(cmd),
    .pop   (pop),
    .head  (head),
    .q_stat(q_stat)
  );

  // expand commands into bytes
  jesc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // checks
  `ASSERT_IMPLY(a_no_push_full, clk, rst, push, !q_stat.full)
  `ASSERT_IMPLY(a_no_pop_empty, clk, rst, pop, !q_stat.empty)
  `ASSERT_IMPLY(a_last_is_nul, clk, rst, m_tvalid && m_tlast, m_tdata == jesc_pkg::CH_NUL)
  `ASSERT_PROP(a_push_on_accept, clk, rst, !push || (s_tvalid && s_tready))

endmodule

`default_nettype wire
